[sv/idfc_pkg.sv]
// Shared types and constants of the infrared distance filter and converter.
`default_nettype none
package idfc_pkg;

  localparam int unsigned NumThresh  = 8;
  localparam int unsigned ThreshW    = 12;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned SampleW    = 12;
  localparam int unsigned ChanW      = 3;
  localparam int unsigned EntryW     = 5;
  localparam int unsigned DistW      = 8;
  localparam int unsigned PresW      = 8;

  localparam logic [ChanW-1:0] UnusedChA = 3'd3;
  localparam logic [ChanW-1:0] UnusedChB = 3'd7;
  localparam logic [DistW-1:0] StepMm    = 8'd5;
  localparam logic [DistW-1:0] NoWallMm  = 8'd255;

  localparam logic FuncLoad   = 1'b0;
  localparam logic FuncSample = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WRD,
    S_UPD,
    S_CHK,
    S_T0,
    S_SCMP,
    S_DIVI,
    S_FIN
  } state_e;

  typedef enum logic [2:0] {
    DS_NONE,
    DS_ZERO,
    DS_NEAR,
    DS_NOWALL,
    DS_LAST,
    DS_INTERP
  } dist_src_e;

  typedef struct packed {
    logic              accept;
    logic              win_upd;
    logic              filt_load;
    logic [EntryW-1:0] tab_idx;
    logic              save_prev;
    logic              div_start;
    dist_src_e         dist_sel;
    logic              out_load;
  } cmd_t;

  typedef struct packed {
    logic sample_ok;
    logic div_done;
    logic unused;
    logic near;
    logic nowall;
    logic out_free;
  } sts_t;

  function automatic logic [ThreshW-1:0] thresh_reset(input logic [CfgIdxW-1:0] idx);
    logic [ThreshW-1:0] v;
    case (idx)
      3'd0:    v = 12'd300;
      3'd2:    v = 12'd300;
      3'd4:    v = 12'd273;
      3'd6:    v = 12'd300;
      default: v = 12'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

[sv/idfc_if.sv]
// Channel interfaces: sample input, result output and configuration writes.
`default_nettype none
interface idfc_in_if;
  logic                           valid;
  logic                           ready;
  logic                           func;
  logic [idfc_pkg::ChanW-1:0]     chan;
  logic [idfc_pkg::EntryW-1:0]    entry_index;
  logic [idfc_pkg::SampleW-1:0]   table_word;
  logic [idfc_pkg::SampleW-1:0]   raw_sample;
  modport source (output valid, func, chan, entry_index, table_word, raw_sample,
                  input ready);
  modport sink (input valid, func, chan, entry_index, table_word, raw_sample,
                output ready);
endinterface

interface idfc_out_if;
  logic                         valid;
  logic                         ready;
  logic [idfc_pkg::ChanW-1:0]   out_chan;
  logic [idfc_pkg::SampleW-1:0] filtered;
  logic [idfc_pkg::DistW-1:0]   distance_mm;
  logic [idfc_pkg::PresW-1:0]   presence_bits;
  modport source (output valid, out_chan, filtered, distance_mm, presence_bits,
                  input ready);
  modport sink (input valid, out_chan, filtered, distance_mm, presence_bits,
                output ready);
endinterface

interface idfc_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [idfc_pkg::CfgIdxW-1:0] index;
  logic [idfc_pkg::ThreshW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[sv/idfc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module idfc_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

[sv/idfc_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none
module idfc_div #(
  parameter int unsigned DW = 18
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [DW-1:0]                dividend_i,
  input  wire logic [idfc_pkg::SampleW-1:0] divisor_i,
  output logic                              done_o,
  output logic      [DW-1:0]                quot_o
);
  localparam int unsigned CW = $clog2(DW + 1);
  localparam int unsigned RW = idfc_pkg::SampleW;

  logic [RW-1:0] rem_q, rem_d, dsr_q;
  logic [DW-1:0] quo_q, quo_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [RW:0]   rs, diff;
  logic          ge;

  always_comb begin
    rs    = {rem_q, quo_q[DW-1]};
    diff  = rs - {1'b0, dsr_q};
    ge    = (rs >= {1'b0, dsr_q});
    rem_d = ge ? diff[RW-1:0] : rs[RW-1:0];
    quo_d = {quo_q[DW-2:0], ge};
    cnt_d  = cnt_q + 1'b1;
    busy_d = busy_q && (cnt_q != CW'(DW - 1));
    done_d = busy_q && (cnt_q == CW'(DW - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      if (busy_q) begin
        cnt_q <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
endmodule
`default_nettype wire

[sv/idfc_ctrl.sv]
// Controller: sequences window update, table search, interpolation and output.
`default_nettype none
module idfc_ctrl #(
  parameter int unsigned TABLE_ENTRIES = 20
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire idfc_pkg::sts_t sts_i,
  output idfc_pkg::cmd_t     cmd_o
);
  localparam int unsigned EW = idfc_pkg::EntryW;

  idfc_pkg::state_e st_q, st_d;
  logic [EW-1:0]    j_q, j_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= idfc_pkg::S_IDLE;
      j_q  <= '0;
    end else begin
      st_q <= st_d;
      j_q  <= j_d;
    end
  end

  always_comb begin
    st_d       = st_q;
    j_d        = j_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.dist_sel = idfc_pkg::DS_NONE;
    case (st_q)
      idfc_pkg::S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && sts_i.sample_ok) begin
          st_d = idfc_pkg::S_WRD;
        end
      end
      idfc_pkg::S_WRD: begin
        st_d = idfc_pkg::S_UPD;
      end
      idfc_pkg::S_UPD: begin
        cmd_o.win_upd   = 1'b1;
        cmd_o.filt_load = 1'b1;
        st_d = idfc_pkg::S_CHK;
      end
      idfc_pkg::S_CHK: begin
        cmd_o.tab_idx = '0;
        if (sts_i.unused) begin
          cmd_o.dist_sel = idfc_pkg::DS_ZERO;
          st_d = idfc_pkg::S_FIN;
        end else begin
          st_d = idfc_pkg::S_T0;
        end
      end
      idfc_pkg::S_T0: begin
        // Entry 0 is on the read port; entry 1 is fetched meanwhile.
        cmd_o.tab_idx = EW'(1);
        j_d = EW'(1);
        if (sts_i.near) begin
          cmd_o.dist_sel = idfc_pkg::DS_NEAR;
          st_d = idfc_pkg::S_FIN;
        end else if (sts_i.nowall) begin
          cmd_o.dist_sel = idfc_pkg::DS_NOWALL;
          st_d = idfc_pkg::S_FIN;
        end else begin
          cmd_o.save_prev = 1'b1;
          st_d = idfc_pkg::S_SCMP;
        end
      end
      idfc_pkg::S_SCMP: begin
        cmd_o.tab_idx = j_q + 1'b1;
        if (sts_i.near) begin
          cmd_o.div_start = 1'b1;
          st_d = idfc_pkg::S_DIVI;
        end else if (j_q == EW'(TABLE_ENTRIES - 1)) begin
          cmd_o.dist_sel = idfc_pkg::DS_LAST;
          st_d = idfc_pkg::S_FIN;
        end else begin
          cmd_o.save_prev = 1'b1;
          j_d = j_q + 1'b1;
        end
      end
      idfc_pkg::S_DIVI: begin
        cmd_o.tab_idx = j_q;
        if (sts_i.div_done) begin
          cmd_o.dist_sel = idfc_pkg::DS_INTERP;
          st_d = idfc_pkg::S_FIN;
        end
      end
      idfc_pkg::S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          st_d = idfc_pkg::S_IDLE;
        end
      end
      default: begin
        st_d = idfc_pkg::S_IDLE;
      end
    endcase
  end

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != idfc_pkg::S_DIVI) |-> !sts_i.div_done)
    else $error("divider finished outside the division state");

  a_j_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == idfc_pkg::S_SCMP |-> (j_q >= EW'(1) && j_q <= EW'(TABLE_ENTRIES - 1)))
    else $error("table search index out of range");

  a_out_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> st_q == idfc_pkg::S_IDLE)
    else $error("result loaded without returning to idle");
endmodule
`default_nettype wire

[sv/idfc_dp.sv]
// Datapath: per-channel window state, calibration tables, divider and result register.
`default_nettype none
module idfc_dp #(
  parameter int unsigned CHANNELS      = 8,
  parameter int unsigned WINDOW        = 16,
  parameter int unsigned TABLE_ENTRIES = 20
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  idfc_in_if.sink             sample_i,
  idfc_out_if.source          result_o,
  idfc_cfg_if.sink            cfg_i,
  input  wire idfc_pkg::cmd_t cmd_i,
  output idfc_pkg::sts_t      sts_o
);
  localparam int unsigned SW  = idfc_pkg::SampleW;
  localparam int unsigned CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned PW  = $clog2(WINDOW);
  localparam int unsigned TW  = $clog2(TABLE_ENTRIES);
  localparam int unsigned SUW = SW + PW;
  localparam int unsigned IW  = SW + 3;
  localparam int unsigned DW  = IW;
  localparam int unsigned DL  = idfc_pkg::DistW;

  logic [SW-1:0]  thr_q  [idfc_pkg::NumThresh];
  logic [PW-1:0]  pos_q  [CHANNELS];
  logic           full_q [CHANNELS];
  logic [SUW-1:0] sum_q  [CHANNELS];
  logic [SW-1:0]  filt_q [CHANNELS];
  logic [DL-1:0]  last_q [CHANNELS];

  logic [idfc_pkg::ChanW-1:0] ch_q;
  logic [CHW-1:0]             ci;
  logic [SW-1:0]  raw_q, f_q, prev_q, win_rdata, tab_rdata;
  logic [DL-1:0]  dist_q, dist_d;
  logic [SUW-1:0] sum_new;
  logic [SW-1:0]  old;
  logic           tab_we;
  logic [DW-1:0]  div_dvd, quot;
  logic [SW-1:0]  div_dsr, part;
  logic           div_done;
  logic [idfc_pkg::PresW-1:0] pres;

  logic           out_valid_q;
  logic [idfc_pkg::ChanW-1:0] out_chan_q;
  logic [SW-1:0]  out_filt_q;
  logic [DL-1:0]  out_dist_q;
  logic [idfc_pkg::PresW-1:0] out_pres_q;

  assign ci = ch_q[CHW-1:0];

  // Configuration registers.
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < idfc_pkg::NumThresh; i++) begin
        thr_q[i] <= idfc_pkg::thresh_reset(idfc_pkg::CfgIdxW'(i));
      end
    end else if (cfg_i.valid) begin
      thr_q[cfg_i.index] <= cfg_i.data;
    end
  end

  // Item fields.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      ch_q  <= sample_i.chan;
      raw_q <= sample_i.raw_sample;
    end
  end

  assign tab_we = cmd_i.accept && (sample_i.func == idfc_pkg::FuncLoad)
               && ({1'b0, sample_i.chan} < 4'(CHANNELS))
               && (sample_i.entry_index < idfc_pkg::EntryW'(TABLE_ENTRIES));

  idfc_ram #(.WIDTH(SW), .DEPTH((1 << CHW) << TW)) u_tab (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .waddr_i ({sample_i.chan[CHW-1:0], sample_i.entry_index[TW-1:0]}),
    .wdata_i (sample_i.table_word),
    .raddr_i ({ci, cmd_i.tab_idx[TW-1:0]}),
    .rdata_o (tab_rdata)
  );

  // Sample window; an entry not yet written since reset reads as zero.
  idfc_ram #(.WIDTH(SW), .DEPTH((1 << CHW) << PW)) u_win (
    .clk_i   (clk_i),
    .we_i    (cmd_i.win_upd),
    .waddr_i ({ci, pos_q[ci]}),
    .wdata_i (raw_q),
    .raddr_i ({ci, pos_q[ci]}),
    .rdata_o (win_rdata)
  );

  assign old     = full_q[ci] ? win_rdata : '0;
  assign sum_new = sum_q[ci] - SUW'(old) + SUW'(raw_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        pos_q[i]  <= '0;
        full_q[i] <= 1'b0;
        sum_q[i]  <= '0;
        filt_q[i] <= '0;
        last_q[i] <= '0;
      end
    end else begin
      if (cmd_i.win_upd) begin
        sum_q[ci] <= sum_new;
        if (pos_q[ci] == PW'(WINDOW - 1)) begin
          pos_q[ci]  <= '0;
          full_q[ci] <= 1'b1;
        end else begin
          pos_q[ci] <= pos_q[ci] + 1'b1;
        end
      end
      if (cmd_i.filt_load) begin
        filt_q[ci] <= sum_new[SUW-1:PW];
      end
      if (cmd_i.out_load) begin
        last_q[ci] <= dist_q;
      end
    end
  end

  // Divider for the interpolation fraction between two table entries.
  assign part    = prev_q - f_q;
  assign div_dvd = DW'(IW'(part) * IW'(idfc_pkg::StepMm));
  assign div_dsr = prev_q - tab_rdata;

  idfc_div #(.DW(DW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  always_comb begin
    case (cmd_i.dist_sel)
      idfc_pkg::DS_ZERO:   dist_d = '0;
      idfc_pkg::DS_NEAR:   dist_d = idfc_pkg::StepMm;
      idfc_pkg::DS_NOWALL: dist_d = idfc_pkg::NoWallMm;
      idfc_pkg::DS_LAST:   dist_d = last_q[ci];
      idfc_pkg::DS_INTERP: dist_d = DL'(cmd_i.tab_idx) * idfc_pkg::StepMm
                                    + DL'(quot[2:0]);
      default:             dist_d = dist_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.filt_load) begin
      f_q <= sum_new[SUW-1:PW];
    end
    if (cmd_i.save_prev) begin
      prev_q <= tab_rdata;
    end
    dist_q <= dist_d;
  end

  always_comb begin
    pres = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      pres[i] = filt_q[i] > thr_q[i];
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_chan_q <= ch_q;
      out_filt_q <= f_q;
      out_dist_q <= dist_q;
      out_pres_q <= pres;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.out_chan      = out_chan_q;
  assign result_o.filtered      = out_filt_q;
  assign result_o.distance_mm   = out_dist_q;
  assign result_o.presence_bits = out_pres_q;

  always_comb begin
    sts_o.sample_ok = (sample_i.func == idfc_pkg::FuncSample)
                   && ({1'b0, sample_i.chan} < 4'(CHANNELS));
    sts_o.div_done  = div_done;
    sts_o.unused    = (ch_q == idfc_pkg::UnusedChA) || (ch_q == idfc_pkg::UnusedChB);
    sts_o.near      = f_q >= tab_rdata;
    sts_o.nowall    = f_q <= thr_q[ch_q];
    sts_o.out_free  = !out_valid_q || result_o.ready;
  end
endmodule
`default_nettype wire

[sv/ir_distance_filter_convert.sv]
// Top level of the infrared distance filter and converter.
// Load items (func 0) write one calibration word and are taken without leaving idle, with
// no result. A sample item (func 1) updates its channel's moving-average window, where
// the average is the running sum shifted right by log2(WINDOW), and is converted to
// millimetres. The time from its acceptance to the acceptance of the next item depends on
// its path: an unused channel, a very near or no-wall reading, interpolation at table
// entry j, or no matching entry. The search is paced by the one-entry-per-cycle read
// of the calibration RAM and by the bit-serial divider of the interpolation fraction.
// The window RAM needs no clearing pass after reset: a per-channel fill flag makes
// unwritten slots read as zero. A finished result waits in the output register while the
// next item is accepted; a result stalled on the output holds the following one in its
// last state.
`default_nettype none
module ir_distance_filter_convert #(
  parameter int unsigned CHANNELS      = 8,
  parameter int unsigned WINDOW        = 16,
  parameter int unsigned TABLE_ENTRIES = 20
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  idfc_in_if.sink    sample_i,
  idfc_out_if.source result_o,
  idfc_cfg_if.sink   cfg_i
);
  idfc_pkg::cmd_t cmd;
  idfc_pkg::sts_t sts;

  idfc_ctrl #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sample_i.valid),
    .in_ready_o (sample_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  idfc_dp #(
    .CHANNELS      (CHANNELS),
    .WINDOW        (WINDOW),
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_i),
    .result_o (result_o),
    .cfg_i    (cfg_i),
    .cmd_i    (cmd),
    .sts_o    (sts)
  );
endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
// Self-checking testbench of the infrared distance filter and converter.
`timescale 1ns / 100ps
module tb_top;

  localparam int unsigned NumCh     = 8;
  localparam int unsigned WinLen    = 16;
  localparam int unsigned NumEntry  = 20;
  localparam int unsigned RandItems = 320;
  localparam int unsigned SettleCyc = 150;
  localparam longint     CycLimit   = 2000000;

  typedef struct packed {
    logic [idfc_pkg::ChanW-1:0]   chan;
    logic [idfc_pkg::SampleW-1:0] filtered;
    logic [idfc_pkg::DistW-1:0]   dist_mm;
    logic [idfc_pkg::PresW-1:0]   pres;
  } reading_t;

  typedef struct packed {
    logic                         func;
    logic [idfc_pkg::ChanW-1:0]   chan;
    logic [idfc_pkg::EntryW-1:0]  entry;
    logic [idfc_pkg::SampleW-1:0] word;
    logic [idfc_pkg::SampleW-1:0] raw;
    logic                         has_dist;
    logic [idfc_pkg::DistW-1:0]   dist_mm;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;
  idfc_in_if  in_if ();
  idfc_out_if out_if ();
  idfc_cfg_if cfg_if ();

  ir_distance_filter_convert u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .sample_i(in_if.sink),
    .result_o(out_if.source),
    .cfg_i   (cfg_if.sink)
  );

  // Predictor state.
  logic [idfc_pkg::ThreshW-1:0] thr_q [NumCh];
  logic [idfc_pkg::SampleW-1:0] win_q [NumCh][WinLen];
  int unsigned                  pos_q [NumCh];
  logic [15:0]                  sum_q [NumCh];
  logic [idfc_pkg::SampleW-1:0] cal_q [NumCh][NumEntry];
  logic [idfc_pkg::DistW-1:0]   last_q[NumCh];

  reading_t    expected_q[$];
  int unsigned fail_cnt;
  longint      cyc_cnt;
  int unsigned level[NumCh];

  function automatic logic [idfc_pkg::SampleW-1:0] avg_of(int unsigned c);
    return idfc_pkg::SampleW'(sum_q[c] / WinLen);
  endfunction

  function automatic logic [idfc_pkg::DistW-1:0] to_mm(int unsigned c,
                                                      logic [idfc_pkg::SampleW-1:0] f);
    int unsigned a0;
    int unsigned a1;
    int unsigned d;
    if (c == idfc_pkg::UnusedChA || c == idfc_pkg::UnusedChB) return '0;
    if (f >= cal_q[c][0]) return idfc_pkg::StepMm;
    if (f <= thr_q[c]) return idfc_pkg::NoWallMm;
    for (int j = 1; j < NumEntry; j++) begin
      a1 = cal_q[c][j];
      if (f >= a1) begin
        a0 = cal_q[c][j-1];
        d = 5 * j + (5 * (a0 - f)) / (a0 - a1);
        return d[idfc_pkg::DistW-1:0];
      end
    end
    return last_q[c];
  endfunction

  // Applies one accepted item to the predictor; returns 1 when it yields a reading.
  function automatic bit apply_item(input stim_row_t s, output reading_t r);
    int unsigned c;
    int unsigned p;
    logic [idfc_pkg::SampleW-1:0] f;
    logic [idfc_pkg::PresW-1:0] pres;
    c = s.chan;
    r = '0;
    if (s.func == idfc_pkg::FuncLoad) begin
      if (s.entry < NumEntry) cal_q[c][s.entry] = s.word;
      return 0;
    end
    p = pos_q[c];
    sum_q[c] = 16'(sum_q[c] - win_q[c][p] + s.raw);
    win_q[c][p] = s.raw;
    pos_q[c] = (p + 1) % WinLen;
    f = avg_of(c);
    last_q[c] = to_mm(c, f);
    pres = '0;
    for (int i = 0; i < NumCh; i++)
      if (avg_of(i) > thr_q[i]) pres[i] = 1'b1;
    r.chan = s.chan;
    r.filtered = f;
    r.dist_mm = last_q[c];
    r.pres = pres;
    return 1;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt > CycLimit) begin
      $display("[ir_distance_filter_convert] ERROR");
      $finish;
    end
  end

  // Result side: random back-pressure, with quiet stretches where ready stays high.
  int unsigned stall_left;
  int unsigned calm_left;
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_if.ready <= 1'b0;
    end else if (calm_left > 0) begin
      calm_left = calm_left - 1;
      out_if.ready <= 1'b1;
    end else begin
      if ($urandom_range(0, 19) == 0) calm_left = $urandom_range(50, 300);
      stall_left = pick_gap();
      out_if.ready <= (stall_left == 0);
    end
  end

  always @(posedge clk_i) begin
    reading_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected reading chan=%0d", out_if.out_chan);
        fail_cnt++;
      end else begin
        want = expected_q.pop_front();
        if (out_if.out_chan !== want.chan) begin
          $error("out_chan exp=%0d got=%0d", want.chan, out_if.out_chan);
          fail_cnt++;
        end
        if (out_if.filtered !== want.filtered) begin
          $error("filtered exp=%0d got=%0d", want.filtered, out_if.filtered);
          fail_cnt++;
        end
        if (out_if.distance_mm !== want.dist_mm) begin
          $error("distance_mm exp=%0d got=%0d", want.dist_mm, out_if.distance_mm);
          fail_cnt++;
        end
        if (out_if.presence_bits !== want.pres) begin
          $error("presence_bits exp=%0h got=%0h", want.pres, out_if.presence_bits);
          fail_cnt++;
        end
      end
    end
  end

  task automatic send_beat(input stim_row_t s);
    reading_t r;
    repeat (pick_gap()) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid       = 1'b1;
    in_if.func        = s.func;
    in_if.chan        = s.chan;
    in_if.entry_index = s.entry;
    in_if.table_word  = s.word;
    in_if.raw_sample  = s.raw;
    do @(posedge clk_i); while (!in_if.ready);
    if (apply_item(s, r)) begin
      if (s.has_dist && r.dist_mm !== s.dist_mm) begin
        $error("distance_mm exp=%0d got=%0d (directed)", s.dist_mm, r.dist_mm);
        fail_cnt++;
      end
      expected_q.push_back(r);
    end
    @(negedge clk_i);
    in_if.valid = 1'b0;
  endtask

  task automatic write_thresh(input logic [idfc_pkg::CfgIdxW-1:0] idx,
                              input logic [idfc_pkg::ThreshW-1:0] val);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = val;
    do @(posedge clk_i); while (!cfg_if.ready);
    thr_q[idx] = val;
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  // Waits until every reading has come back and the block has gone quiet.
  task automatic drain();
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (SettleCyc) @(negedge clk_i);
  endtask

  function automatic stim_row_t load_row(int unsigned c, int unsigned e, int unsigned w);
    stim_row_t s;
    s = '0;
    s.func = idfc_pkg::FuncLoad;
    s.chan = idfc_pkg::ChanW'(c);
    s.entry = idfc_pkg::EntryW'(e);
    s.word = idfc_pkg::SampleW'(w);
    s.raw = idfc_pkg::SampleW'($urandom_range(0, 4095));
    return s;
  endfunction

  function automatic stim_row_t sample_row(int unsigned c, int unsigned raw);
    stim_row_t s;
    s = '0;
    s.func = idfc_pkg::FuncSample;
    s.chan = idfc_pkg::ChanW'(c);
    s.raw = idfc_pkg::SampleW'(raw);
    s.entry = idfc_pkg::EntryW'($urandom_range(0, 31));
    s.word = idfc_pkg::SampleW'($urandom_range(0, 4095));
    return s;
  endfunction

  // Loads a decreasing calibration curve with random steps into one channel.
  task automatic load_curve(input int unsigned c);
    int unsigned w;
    w = $urandom_range(2500, 4095);
    for (int e = 0; e < NumEntry; e++) begin
      send_beat(load_row(c, e, w));
      w = (w > 220) ? w - $urandom_range(1, 200) : w;
    end
  endtask

  stim_row_t dir_tab[$];
  stim_row_t s;
  int unsigned c;
  int unsigned sent;
  int unsigned lv;

  initial begin
    cyc_cnt = 0;
    fail_cnt = 0;
    stall_left = 0;
    calm_left = 0;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.func = idfc_pkg::FuncLoad;
    in_if.chan = '0;
    in_if.entry_index = '0;
    in_if.table_word = '0;
    in_if.raw_sample = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    out_if.ready = 1'b0;
    for (int i = 0; i < NumCh; i++) begin
      thr_q[i] = idfc_pkg::thresh_reset(idfc_pkg::CfgIdxW'(i));
      pos_q[i] = 0;
      sum_q[i] = '0;
      last_q[i] = '0;
      level[i] = $urandom_range(0, 4095);
      for (int k = 0; k < WinLen; k++) win_q[i][k] = '0;
      for (int k = 0; k < NumEntry; k++) cal_q[i][k] = '0;
    end
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Every table entry is written before any sample reads it.
    for (int i = 0; i < NumCh; i++)
      for (int e = 0; e < NumEntry; e++)
        send_beat(load_row(i, e, 4000 - 200 * e));

    // Directed part: unused channels, no wall, very near, ignored entry, extremes.
    s = sample_row(idfc_pkg::UnusedChA, 4095); s.has_dist = 1; s.dist_mm = 0;
    dir_tab.push_back(s);
    s = sample_row(idfc_pkg::UnusedChB, 4095); s.has_dist = 1; s.dist_mm = 0;
    dir_tab.push_back(s);
    s = sample_row(0, 0); s.has_dist = 1; s.dist_mm = idfc_pkg::NoWallMm;
    dir_tab.push_back(s);
    dir_tab.push_back(load_row(1, 0, 0));
    s = sample_row(1, 4095); s.has_dist = 1; s.dist_mm = idfc_pkg::StepMm;
    dir_tab.push_back(s);
    dir_tab.push_back(load_row(1, 31, 4095));
    dir_tab.push_back(load_row(1, NumEntry, 0));
    dir_tab.push_back(load_row(1, 0, 4095));
    s = sample_row(1, 4095);
    dir_tab.push_back(s);
    for (int k = 0; k < 8; k++) dir_tab.push_back(sample_row(2, 4095));
    dir_tab.push_back(sample_row(4, 4095));
    dir_tab.push_back(sample_row(5, 2730));
    dir_tab.push_back(sample_row(6, 1365));
    dir_tab.push_back(load_row(7, 19, 4095));
    foreach (dir_tab[i]) send_beat(dir_tab[i]);
    drain();

    // Random phases, each under a different threshold setting.
    for (int ph = 0; ph < 4; ph++) begin
      for (int i = 0; i < NumCh; i++)
        case (ph)
          0: write_thresh(idfc_pkg::CfgIdxW'(i), '0);
          1: write_thresh(idfc_pkg::CfgIdxW'(i), idfc_pkg::ThreshW'(4095));
          2: write_thresh(idfc_pkg::CfgIdxW'(i),
                          idfc_pkg::thresh_reset(idfc_pkg::CfgIdxW'(i)));
          default: write_thresh(idfc_pkg::CfgIdxW'(i),
                                idfc_pkg::ThreshW'($urandom_range(0, 3000)));
        endcase
      sent = 0;
      while (sent < RandItems / 4) begin
        c = $urandom_range(0, NumCh - 1);
        case ($urandom_range(0, 39))
          0: load_curve(c);
          1: send_beat(load_row(c, $urandom_range(0, 31), $urandom_range(0, 4095)));
          2: level[c] = $urandom_range(0, 4095);
          default: begin
            // Samples mostly wander around the channel's level, sometimes jump anywhere.
            lv = level[c] + $urandom_range(0, 300);
            lv = (lv > 4245) ? 4095 : ((lv < 150) ? 0 : lv - 150);
            if ($urandom_range(0, 9) == 0) lv = $urandom_range(0, 4095);
            send_beat(sample_row(c, lv));
            sent++;
          end
        endcase
      end
      drain();
    end

    if (fail_cnt == 0) begin
      $display("[ir_distance_filter_convert] OK");
    end else begin
      $display("[ir_distance_filter_convert] ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
sv/idfc_pkg.sv
sv/idfc_if.sv
sv/idfc_ram.sv
sv/idfc_div.sv
sv/idfc_ctrl.sv
sv/idfc_dp.sv
sv/ir_distance_filter_convert.sv
tb/sv/tb_top.sv
